// File: rtl/edf_pkg.sv
package edf_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int TIME_BITS_DEF   = 32;
  localparam int TALLY_BITS      = 16;

  typedef enum logic [1:0] {
    OP_RELEASE  = 2'd0,
    OP_COMPLETE = 2'd1,
    OP_TICK     = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_ACCEPTED = 3'd1,
    EV_FULL     = 3'd2,
    EV_DISPATCH = 3'd3,
    EV_ON_TIME  = 3'd4,
    EV_LATE     = 3'd5,
    EV_DROPPED  = 3'd6,
    EV_UNKNOWN  = 3'd7
  } ev_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;
    logic clr_ptr;
    logic inc_ptr;
    logic insert;
    logic remove;
    logic keep_stamp;
    logic bump_on;
    logic bump_late;
    logic dispatch;
    logic free;
    logic evt_in;
    logic evt_zero;
    logic capture;
    ev_t  code;
    logic push;
    logic push_last;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic ptr_end;
    logic match;
    logic dl_lt;
    logic overdue;
    logic ontime;
    logic busy;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/edf_ctrl.sv
module edf_ctrl import edf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_INS, S_CMP, S_SWEEP, S_DISP, S_EMIT, S_FINISH
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  ev_t    code_r, code_nxt;
  logic   hold_v_r, hold_v_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = code_r;
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    code_nxt   = code_r;
    hold_v_nxt = hold_v_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          cmd.clr_ptr  = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        ret_nxt = S_FINISH;
        unique case (st.op)
          OP_RELEASE: begin
            if (st.full) begin
              cmd.evt_in = 1'b1;
              code_nxt   = EV_FULL;
              state_nxt  = S_EMIT;
            end else begin
              state_nxt = S_INS;
            end
          end
          OP_COMPLETE: state_nxt = S_CMP;
          OP_TICK:     state_nxt = S_SWEEP;
          default: begin
            cmd.evt_zero = 1'b1;
            code_nxt     = EV_NONE;
            state_nxt    = S_EMIT;
          end
        endcase
      end
      // Walk to the first slot with a later deadline, then insert there
      S_INS: begin
        if (st.ptr_end || st.dl_lt) begin
          cmd.insert = 1'b1;
          cmd.evt_in = 1'b1;
          code_nxt   = EV_ACCEPTED;
          state_nxt  = S_EMIT;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      // Find the task by id and retire it
      S_CMP: begin
        priority if (st.ptr_end) begin
          cmd.evt_in = 1'b1;
          code_nxt   = EV_UNKNOWN;
          state_nxt  = S_EMIT;
        end else if (st.match) begin
          cmd.remove     = 1'b1;
          cmd.keep_stamp = 1'b1;
          cmd.free       = 1'b1;
          cmd.bump_on    = st.ontime;
          cmd.bump_late  = !st.ontime;
          code_nxt       = st.ontime ? EV_ON_TIME : EV_LATE;
          state_nxt      = S_EMIT;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      // Drop overdue waiting tasks; the pointer holds after a removal
      S_SWEEP: begin
        priority if (st.ptr_end) begin
          state_nxt = S_DISP;
        end else if (st.overdue) begin
          cmd.remove    = 1'b1;
          cmd.bump_late = 1'b1;
          code_nxt      = EV_DROPPED;
          ret_nxt       = S_SWEEP;
          state_nxt     = S_EMIT;
        end else begin
          cmd.inc_ptr = 1'b1;
        end
      end
      S_DISP: begin
        priority if (!st.busy && !st.empty) begin
          cmd.dispatch = 1'b1;
          code_nxt     = EV_DISPATCH;
          ret_nxt      = S_FINISH;
          state_nxt    = S_EMIT;
        end else if (hold_v_r) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.evt_zero = 1'b1;
          code_nxt     = EV_NONE;
          ret_nxt      = S_FINISH;
          state_nxt    = S_EMIT;
        end
      end
      // Send any held result on, then hold the new one
      S_EMIT: begin
        if (!hold_v_r || st.out_free) begin
          cmd.push    = hold_v_r;
          cmd.capture = 1'b1;
          hold_v_nxt  = 1'b1;
          state_nxt   = ret_r;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
          hold_v_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_FINISH;
      code_r   <= EV_NONE;
      hold_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      code_r   <= code_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

endmodule

// File: rtl/edf_dpath.sv
module edf_dpath import edf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int CW = $clog2(TABLE_DEPTH + 1),
  localparam int IW = $clog2(TABLE_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output stat_t                 st,
  input  logic [1:0]            in_opcode,
  input  logic [ID_BITS-1:0]    in_task_id,
  input  logic [TIME_BITS-1:0]  in_task_deadline,
  input  logic [TIME_BITS-1:0]  in_current_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_res,
  output logic [ID_BITS-1:0]    out_event_task_id,
  output logic [TIME_BITS-1:0]  out_event_release_time,
  output logic [CW-1:0]         out_active_count,
  output logic [TALLY_BITS-1:0] out_done_on_time_count,
  output logic [TALLY_BITS-1:0] out_overdue_total,
  output logic                  out_last
);

  localparam logic [TALLY_BITS-1:0] TALLY_MAX = '1;

  logic [ID_BITS-1:0]    task_r [TABLE_DEPTH];
  logic [TIME_BITS-1:0]  dl_r   [TABLE_DEPTH];
  logic [TIME_BITS-1:0]  st_r   [TABLE_DEPTH];
  logic [ID_BITS-1:0]    task_nxt [TABLE_DEPTH];
  logic [TIME_BITS-1:0]  dl_nxt   [TABLE_DEPTH];
  logic [TIME_BITS-1:0]  st_nxt   [TABLE_DEPTH];
  logic [CW-1:0]         count_r, count_nxt, ptr_r;
  logic [IW-1:0]         run_r, run_nxt, pidx;
  logic                  busy_r, busy_nxt;
  logic [TALLY_BITS-1:0] on_r, late_r;
  op_t                   op_r;
  logic [ID_BITS-1:0]    id_r, evt_id_r;
  logic [TIME_BITS-1:0]  dlin_r, now_r, evt_rel_r;
  ev_t                   h_code_r;
  logic [ID_BITS-1:0]    h_id_r;
  logic [TIME_BITS-1:0]  h_rel_r;
  logic [CW-1:0]         h_cnt_r;
  logic [TALLY_BITS-1:0] h_on_r, h_late_r;

  assign pidx = ptr_r[IW-1:0];

  // Status at the scan pointer
  always_comb begin
    st          = '0;
    st.op       = op_r;
    st.full     = (count_r >= CW'(TABLE_DEPTH));
    st.empty    = (count_r == '0);
    st.ptr_end  = (ptr_r >= count_r);
    st.match    = (task_r[pidx] == id_r);
    st.dl_lt    = (dlin_r < dl_r[pidx]);
    st.overdue  = !(busy_r && (CW'(run_r) == ptr_r)) && (dl_r[pidx] <= now_r);
    st.ontime   = (now_r < dl_r[pidx]);
    st.busy     = busy_r;
    st.out_free = !out_valid || out_ready;
  end

  // Table shifts: each slot keeps its value, takes a neighbor's or takes the new task; dispatch stamps slot 0
  always_comb begin
    task_nxt  = task_r;
    dl_nxt    = dl_r;
    st_nxt    = st_r;
    count_nxt = count_r;
    run_nxt   = run_r;
    busy_nxt  = busy_r;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (cmd.insert) begin
        if (CW'(i) == ptr_r) begin
          task_nxt[i] = id_r;
          dl_nxt[i]   = dlin_r;
          st_nxt[i]   = '0;
        end else if (CW'(i) > ptr_r && CW'(i) <= count_r) begin
          task_nxt[i] = task_r[(i + TABLE_DEPTH - 1) % TABLE_DEPTH];
          dl_nxt[i]   = dl_r[(i + TABLE_DEPTH - 1) % TABLE_DEPTH];
          st_nxt[i]   = st_r[(i + TABLE_DEPTH - 1) % TABLE_DEPTH];
        end
      end
      if (cmd.remove && CW'(i) >= ptr_r && CW'(i + 1) < count_r) begin
        task_nxt[i] = task_r[(i + 1) % TABLE_DEPTH];
        dl_nxt[i]   = dl_r[(i + 1) % TABLE_DEPTH];
        st_nxt[i]   = st_r[(i + 1) % TABLE_DEPTH];
      end
    end
    if (cmd.insert) begin
      count_nxt = count_r + 1'b1;
      if (busy_r && CW'(run_r) >= ptr_r) run_nxt = run_r + 1'b1;
    end
    if (cmd.remove) begin
      count_nxt = count_r - 1'b1;
      if (busy_r) begin
        if (CW'(run_r) == ptr_r) busy_nxt = 1'b0;
        else if (CW'(run_r) > ptr_r) run_nxt = run_r - 1'b1;
      end
    end
    if (cmd.free) begin
      busy_nxt = 1'b0;
      run_nxt  = '0;
    end
    if (cmd.dispatch) begin
      busy_nxt  = 1'b1;
      run_nxt   = '0;
      st_nxt[0] = now_r;
    end
  end

  // Table and processor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      run_r   <= '0;
      on_r    <= '0;
      late_r  <= '0;
      ptr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      run_r   <= run_nxt;
      if (cmd.bump_on && on_r != TALLY_MAX) on_r <= on_r + 1'b1;
      if (cmd.bump_late && late_r != TALLY_MAX) late_r <= late_r + 1'b1;
      if (cmd.clr_ptr) ptr_r <= '0;
      else if (cmd.inc_ptr) ptr_r <= ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    task_r <= task_nxt;
    dl_r   <= dl_nxt;
    st_r   <= st_nxt;
    if (cmd.latch_in) begin
      op_r   <= op_t'(in_opcode);
      id_r   <= in_task_id;
      dlin_r <= in_task_deadline;
      now_r  <= in_current_time;
    end
    // Event id and release time for the next capture
    if (cmd.remove) begin
      evt_id_r  <= task_r[pidx];
      evt_rel_r <= cmd.keep_stamp ? st_r[pidx] : '0;
    end else if (cmd.dispatch) begin
      evt_id_r  <= task_r[0];
      evt_rel_r <= now_r;
    end else if (cmd.evt_in) begin
      evt_id_r  <= id_r;
      evt_rel_r <= '0;
    end else if (cmd.evt_zero) begin
      evt_id_r  <= '0;
      evt_rel_r <= '0;
    end
    if (cmd.capture) begin
      h_code_r <= cmd.code;
      h_id_r   <= evt_id_r;
      h_rel_r  <= evt_rel_r;
      h_cnt_r  <= count_r;
      h_on_r   <= on_r;
      h_late_r <= late_r;
    end
    if (cmd.push) begin
      out_event_res          <= h_code_r;
      out_event_task_id      <= h_id_r;
      out_event_release_time <= h_rel_r;
      out_active_count       <= h_cnt_r;
      out_done_on_time_count <= h_on_r;
      out_overdue_total      <= h_late_r;
      out_last               <= cmd.push_last;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (cmd.push) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

endmodule

// File: rtl/edf_task_scheduler.sv
// EDF task table: one transfer in, one to sixteen results out.
// A release walks to its insert position (not when full), a completion to its slot,
// a tick sweeps the table dropping overdue tasks and then dispatches; results wait
// while the result side stalls. One item in flight at a time, set by the single
// scan pointer walking the table one slot per cycle, pausing while a result is emitted.
// Synchronous active-low reset empties the table, frees the CPU, clears tallies.
module edf_task_scheduler import edf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int TIME_BITS   = TIME_BITS_DEF,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_opcode,
  input  logic [ID_BITS-1:0]    in_task_id,
  input  logic [TIME_BITS-1:0]  in_task_deadline,
  input  logic [TIME_BITS-1:0]  in_current_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_event_res,
  output logic [ID_BITS-1:0]    out_event_task_id,
  output logic [TIME_BITS-1:0]  out_event_release_time,
  output logic [CW-1:0]         out_active_count,
  output logic [TALLY_BITS-1:0] out_done_on_time_count,
  output logic [TALLY_BITS-1:0] out_overdue_total,
  output logic                  out_last
);

  cmd_t  cmd;
  stat_t st;

  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  edf_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ID_BITS     (ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .in_opcode              (in_opcode),
    .in_task_id             (in_task_id),
    .in_task_deadline       (in_task_deadline),
    .in_current_time        (in_current_time),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_event_res          (out_event_res),
    .out_event_task_id      (out_event_task_id),
    .out_event_release_time (out_event_release_time),
    .out_active_count       (out_active_count),
    .out_done_on_time_count (out_done_on_time_count),
    .out_overdue_total      (out_overdue_total),
    .out_last               (out_last)
  );

endmodule
